[src/xyz_to_xyy_pixel_top_macros.svh]
// ----------------------------------------------------------------------------
// xyz_to_xyy_pixel_top_macros.svh
// assertion macros for the xyz to xyY chromaticity block
// ----------------------------------------------------------------------------
`ifndef XYZ_TO_XYY_PIXEL_TOP_MACROS_SVH
`define XYZ_TO_XYY_PIXEL_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define XYY_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("xyy assertion failed");

// next-cycle implication, disabled during reset
`define XYY_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("xyy assertion failed");

`endif

[src/xyy_pkg.sv]
// ----------------------------------------------------------------------------
// xyy_pkg
// shared defaults for the xyz to xyY chromaticity block
// ----------------------------------------------------------------------------
`default_nettype none

package xyy_pkg;

  // default width of one tristimulus sample
  localparam int DEFAULT_SAMPLE_BITS   = 16;
  // default number of fraction bits of the chromaticity outputs
  localparam int DEFAULT_FRACTION_BITS = 16;

endpackage

`default_nettype wire

[src/xyy_div_cell.sv]
// ----------------------------------------------------------------------------
// xyy_div_cell
// one restoring-division step for both chromaticity quotients, registered
// ----------------------------------------------------------------------------
`default_nettype none

module xyy_div_cell #(
  parameter int SAMPLE_BITS   = xyy_pkg::DEFAULT_SAMPLE_BITS,
  parameter int FRACTION_BITS = xyy_pkg::DEFAULT_FRACTION_BITS,
  parameter bit FIRST         = 1'b0
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       valid_in,
  input  wire logic [SAMPLE_BITS+2:0]     rem_x_in,
  input  wire logic [SAMPLE_BITS+2:0]     rem_y_in,
  input  wire logic [FRACTION_BITS:0]     quot_x_in,
  input  wire logic [FRACTION_BITS:0]     quot_y_in,
  input  wire logic [SAMPLE_BITS+1:0]     sum_in,
  input  wire logic [SAMPLE_BITS-1:0]     lum_in,
  output logic                            valid_out,
  output logic [SAMPLE_BITS+2:0]          rem_x_out,
  output logic [SAMPLE_BITS+2:0]          rem_y_out,
  output logic [FRACTION_BITS:0]          quot_x_out,
  output logic [FRACTION_BITS:0]          quot_y_out,
  output logic [SAMPLE_BITS+1:0]          sum_out,
  output logic [SAMPLE_BITS-1:0]          lum_out
);
  import xyy_pkg::*;

  localparam int RW = SAMPLE_BITS + 3;
  localparam int QW = FRACTION_BITS + 1;

  logic [RW-1:0] shift_x;
  logic [RW-1:0] shift_y;
  logic [RW-1:0] divisor;
  logic          ge_x;
  logic          ge_y;
  logic [RW-1:0] rem_x_next;
  logic [RW-1:0] rem_y_next;

  // shift in the next dividend bit (always zero), except on the first step
  always_comb begin
    if (FIRST) begin
      shift_x = rem_x_in;
      shift_y = rem_y_in;
    end else begin
      shift_x = {rem_x_in[RW-2:0], 1'b0};
      shift_y = {rem_y_in[RW-2:0], 1'b0};
    end
  end

  // compare and conditional subtract
  assign divisor    = {1'b0, sum_in};
  assign ge_x       = (shift_x >= divisor);
  assign ge_y       = (shift_y >= divisor);
  assign rem_x_next = ge_x ? (shift_x - divisor) : shift_x;
  assign rem_y_next = ge_y ? (shift_y - divisor) : shift_y;

  // valid bit of this stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  // payload of this stage
  always_ff @(posedge clk) begin
    if (en) begin
      rem_x_out  <= rem_x_next;
      rem_y_out  <= rem_y_next;
      quot_x_out <= {quot_x_in[QW-2:0], ge_x};
      quot_y_out <= {quot_y_in[QW-2:0], ge_y};
      sum_out    <= sum_in;
      lum_out    <= lum_in;
    end
  end

endmodule

`default_nettype wire

[src/xyz_to_xyy_pixel_top.sv]
// each pixel passes through every registered cell of the chain from input accept to output valid
// throughput: one pixel per cycle while the output is not stalled; one division cell per quotient bit in a chain
// a stall on the output side holds the whole chain in place
// reset: rst is synchronous and active high, it clears all stage valid bits
// ----------------------------------------------------------------------------
// xyz_to_xyy_pixel_top
// cie xyz to xyY chromaticity, pipelined restoring division over a cell chain
// ----------------------------------------------------------------------------
`default_nettype none

`include "xyz_to_xyy_pixel_top_macros.svh"

module xyz_to_xyy_pixel_top #(
  parameter int SAMPLE_BITS   = xyy_pkg::DEFAULT_SAMPLE_BITS,
  parameter int FRACTION_BITS = xyy_pkg::DEFAULT_FRACTION_BITS,
  localparam int IN_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * FRACTION_BITS + 2 + SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // fields from bit 0 up: tri_x, tri_y, tri_z, zero padding
  input  wire logic [IN_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // fields from bit 0 up: chroma_x, chroma_y, luminance, zero padding
  output logic [OUT_W-1:0]      m_tdata
);
  import xyy_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int QW = FRACTION_BITS + 1;
  localparam int SW = SAMPLE_BITS + 2;
  localparam int RW = SAMPLE_BITS + 3;
  localparam int PAD_W = OUT_W - (2 * QW + SB);
  localparam logic [QW-1:0] UNITY = {1'b1, {FRACTION_BITS{1'b0}}};

  logic [SB-1:0] tri_x;
  logic [SB-1:0] tri_y;
  logic [SB-1:0] tri_z;
  logic          en;

  logic          valid [0:QW];
  logic [RW-1:0] rem_x [0:QW];
  logic [RW-1:0] rem_y [0:QW];
  logic [QW-1:0] quot_x [0:QW];
  logic [QW-1:0] quot_y [0:QW];
  logic [SW-1:0] sum   [0:QW];
  logic [SB-1:0] lum   [0:QW];

  logic [QW-1:0] chroma_x;
  logic [QW-1:0] chroma_y;
  logic          sum_zero;

  // unpack input item
  assign tri_x = s_tdata[SB-1:0];
  assign tri_y = s_tdata[2*SB-1:SB];
  assign tri_z = s_tdata[3*SB-1:2*SB];

  // chain advances whenever the last stage is empty or being taken
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // head of the chain: remainders start at the parts, sum at full width
  assign valid[0]  = s_tvalid;
  assign rem_x[0]  = {3'b000, tri_x};
  assign rem_y[0]  = {3'b000, tri_y};
  assign quot_x[0] = '0;
  assign quot_y[0] = '0;
  assign sum[0]    = {2'b00, tri_x} + {2'b00, tri_y} + {2'b00, tri_z};
  assign lum[0]    = tri_y;

  // one cell per quotient bit, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_cell
    xyy_div_cell #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .FRACTION_BITS(FRACTION_BITS),
      .FIRST        (k == 0)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (valid[k]),
      .rem_x_in  (rem_x[k]),
      .rem_y_in  (rem_y[k]),
      .quot_x_in (quot_x[k]),
      .quot_y_in (quot_y[k]),
      .sum_in    (sum[k]),
      .lum_in    (lum[k]),
      .valid_out (valid[k+1]),
      .rem_x_out (rem_x[k+1]),
      .rem_y_out (rem_y[k+1]),
      .quot_x_out(quot_x[k+1]),
      .quot_y_out(quot_y[k+1]),
      .sum_out   (sum[k+1]),
      .lum_out   (lum[k+1])
    );
  end

  // zero sum forces both chromaticities to zero
  assign sum_zero = (sum[QW] == '0);
  assign chroma_x = sum_zero ? '0 : quot_x[QW];
  assign chroma_y = sum_zero ? '0 : quot_y[QW];

  // pack output item
  assign m_tvalid = valid[QW];
  assign m_tdata  = {{PAD_W{1'b0}}, lum[QW], chroma_y, chroma_x};

  // truncated chromaticities never add up to more than one
  `XYY_ASSERT_NOW(a_chroma_sum, clk, rst, m_tvalid,
    ({1'b0, chroma_x} + {1'b0, chroma_y}) <= {1'b0, UNITY})

  // zero luminance means zero y chromaticity
  `XYY_ASSERT_NOW(a_lum_zero, clk, rst, m_tvalid && (lum[QW] == '0), chroma_y == '0)

  // x at full scale leaves nothing for y
  `XYY_ASSERT_NOW(a_x_unity, clk, rst, m_tvalid && (chroma_x == UNITY), chroma_y == '0)

  // an item in the second to last cell reaches the output on an unstalled cycle
  `XYY_ASSERT_NEXT(a_tail_move, clk, rst, valid[QW-1] && en, m_tvalid)

endmodule

`default_nettype wire
